>>> design/dtem_pkg.sv
`default_nettype none

package dtem_pkg;

    // configuration register indexes
    localparam logic CfgForcedHelm   = 1'b0;
    localparam logic CfgReverseDrive = 1'b1;

    localparam logic signed [7:0]  HelmFollow    = -8'sd128;
    localparam logic signed [7:0]  FracLow       = 8'sd32;
    localparam logic signed [7:0]  FracHigh      = 8'sd96;
    localparam int                 FracShift     = 6;
    localparam logic signed [15:0] PowerMax      = 16'sd32767;
    localparam logic signed [15:0] PowerMin      = -16'sd32768;
    localparam logic [10:0]        PulseCenter   = 11'd1500;
    localparam logic signed [10:0] PulseSpan     = 11'sd400;
    localparam logic signed [10:0] PulseOffset   = 11'sd25;

    typedef struct packed {
        logic signed [7:0] forced_helm;
        logic              reverse_drive;
    } dtem_cfg_t;

    typedef struct packed {
        logic signed [7:0] helm;
        logic signed [7:0] left_frac;
        logic signed [7:0] right_frac;
    } dtem_mix_t;

endpackage

`default_nettype wire

>>> design/dtem_cfg_regs.sv
`default_nettype none

module dtem_cfg_regs (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic              cfg_index,
    input  wire logic [7:0]        cfg_data,
    output dtem_pkg::dtem_cfg_t    cfg
);

    dtem_pkg::dtem_cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.forced_helm   <= '0;
            cfg_reg.reverse_drive <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                dtem_pkg::CfgForcedHelm:   cfg_reg.forced_helm   <= $signed(cfg_data);
                dtem_pkg::CfgReverseDrive: cfg_reg.reverse_drive <= cfg_data[0];
                default:                   cfg_reg <= cfg_reg;
            endcase
        end
    end

endmodule

`default_nettype wire

>>> design/dtem_helm.sv
`default_nettype none

module dtem_helm (
    input  wire dtem_pkg::dtem_cfg_t cfg,
    input  wire logic [7:0]          heading,
    input  wire logic [7:0]          target_heading,
    input  wire logic                fix_ok,
    input  wire logic                mppt_on,
    output dtem_pkg::dtem_mix_t      mix
);

    logic signed [8:0] diff;
    logic signed [8:0] diff_adj;
    logic signed [8:0] half;
    logic              follow;
    logic              idle;
    logic signed [7:0] helm;
    logic signed [7:0] lf;
    logic signed [7:0] rf;

    // no wrap on heading error; halve rounding toward zero
    assign diff     = $signed({1'b0, target_heading}) - $signed({1'b0, heading});
    assign diff_adj = diff + $signed({8'd0, diff[8]});
    assign half     = diff_adj >>> 1;

    assign follow = (cfg.forced_helm == dtem_pkg::HelmFollow);
    assign idle   = !fix_ok && mppt_on && follow;

    always_comb
    begin
        if (idle)
            helm = '0;
        else if (follow)
            helm = half[7:0];
        else
            helm = cfg.forced_helm;

        lf = (helm <= dtem_pkg::FracLow) ? helm + dtem_pkg::FracLow
                                         : dtem_pkg::FracHigh - helm;
        rf = (helm <= -dtem_pkg::FracLow) ? helm + dtem_pkg::FracHigh
                                          : dtem_pkg::FracLow - helm;
        if (cfg.reverse_drive)
        begin
            lf = -lf;
            rf = -rf;
        end
        if (idle)
        begin
            lf = '0;
            rf = '0;
        end

        mix.helm       = helm;
        mix.left_frac  = lf;
        mix.right_frac = rf;
    end

endmodule

`default_nettype wire

>>> design/dtem_motor_lane.sv
`default_nettype none

module dtem_motor_lane (
    input  wire logic [15:0]        power_budget,
    input  wire logic signed [7:0]  frac,
    output logic signed [15:0]      power,
    output logic [10:0]             pulse_us
);

    logic signed [24:0] prod;
    logic signed [24:0] prod_adj;
    logic signed [18:0] scaled;
    logic signed [10:0] offs;
    logic signed [11:0] pulse_sum;

    assign prod     = $signed({1'b0, power_budget}) * frac;
    // bias negatives so the shift truncates toward zero
    assign prod_adj = prod + (prod[24] ? 25'sd63 : 25'sd0);
    assign scaled   = prod_adj[24:dtem_pkg::FracShift];

    always_comb
    begin
        if (scaled > 19'(dtem_pkg::PowerMax))
            power = dtem_pkg::PowerMax;
        else if (scaled < 19'(dtem_pkg::PowerMin))
            power = dtem_pkg::PowerMin;
        else
            power = scaled[15:0];

        if (power == 16'sd0)
            offs = '0;
        else if (power == -16'sd1)
            offs = -11'sd2 - dtem_pkg::PulseOffset;
        else if (power < 16'sd0)
        begin
            if (power < 16'(-dtem_pkg::PulseSpan + dtem_pkg::PulseOffset))
                offs = -dtem_pkg::PulseSpan;
            else
                offs = power[10:0] - dtem_pkg::PulseOffset;
        end
        else
        begin
            if (power > 16'(dtem_pkg::PulseSpan - dtem_pkg::PulseOffset))
                offs = dtem_pkg::PulseSpan;
            else
                offs = power[10:0] + dtem_pkg::PulseOffset;
        end
    end

    assign pulse_sum = $signed({1'b0, dtem_pkg::PulseCenter}) + 12'(offs);
    assign pulse_us  = pulse_sum[10:0];

endmodule

`default_nettype wire

>>> design/differential_thrust_esc_mixer.sv
`default_nettype none

// Two-motor thrust mixer with ESC pulse mapping. Each input beat (budget,
// heading, target, fix and MPPT flags) yields one result beat: the helm
// applied, left/right power saturated to int16 and 1100..1900 us pulses.
// Beats flow one per clock unless out_ready stalls, from the input
// register through the mixer and the 16x8 multiply per motor into the
// result register. Config (forced_helm, reverse_drive) is written through
// the cfg port, which is always ready, and should only change while idle.
module differential_thrust_esc_mixer (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic               cfg_index,
    input  wire logic [7:0]         cfg_data,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [15:0]        power_budget,
    input  wire logic [7:0]         heading,
    input  wire logic [7:0]         target_heading,
    input  wire logic               fix_ok,
    input  wire logic               mppt_on,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic signed [7:0]       helm_used,
    output logic signed [15:0]      left_power,
    output logic signed [15:0]      right_power,
    output logic [10:0]             left_pulse_us,
    output logic [10:0]             right_pulse_us
);

    dtem_pkg::dtem_cfg_t cfg;
    dtem_pkg::dtem_mix_t mix;

    logic        s1_valid_reg;
    logic [15:0] budget_reg;
    logic [7:0]  heading_reg;
    logic [7:0]  target_reg;
    logic        fix_reg;
    logic        mppt_reg;

    logic              out_valid_reg;
    logic signed [7:0]  helm_reg;
    logic signed [15:0] lpow_reg;
    logic signed [15:0] rpow_reg;
    logic [10:0]        lpulse_reg;
    logic [10:0]        rpulse_reg;

    logic signed [15:0] lpow_next;
    logic signed [15:0] rpow_next;
    logic [10:0]        lpulse_next;
    logic [10:0]        rpulse_next;

    logic out_en;
    logic s1_en;

    dtem_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    assign out_en   = !out_valid_reg || out_ready;
    assign s1_en    = !s1_valid_reg || out_en;
    assign in_ready = s1_en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (s1_en)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (s1_en && in_valid)
        begin
            budget_reg  <= power_budget;
            heading_reg <= heading;
            target_reg  <= target_heading;
            fix_reg     <= fix_ok;
            mppt_reg    <= mppt_on;
        end
    end

    dtem_helm u_helm (
        .cfg            (cfg),
        .heading        (heading_reg),
        .target_heading (target_reg),
        .fix_ok         (fix_reg),
        .mppt_on        (mppt_reg),
        .mix            (mix)
    );

    dtem_motor_lane u_left (
        .power_budget (budget_reg),
        .frac         (mix.left_frac),
        .power        (lpow_next),
        .pulse_us     (lpulse_next)
    );

    dtem_motor_lane u_right (
        .power_budget (budget_reg),
        .frac         (mix.right_frac),
        .power        (rpow_next),
        .pulse_us     (rpulse_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_en)
            out_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (out_en && s1_valid_reg)
        begin
            helm_reg   <= mix.helm;
            lpow_reg   <= lpow_next;
            rpow_reg   <= rpow_next;
            lpulse_reg <= lpulse_next;
            rpulse_reg <= rpulse_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign helm_used      = helm_reg;
    assign left_power     = lpow_reg;
    assign right_power    = rpow_reg;
    assign left_pulse_us  = lpulse_reg;
    assign right_pulse_us = rpulse_reg;

    // full pipe with stalled output must back-pressure the input
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && out_valid_reg && !out_ready |-> !in_ready)
        else $error("input accepted while pipeline full");

    a_zero_center: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && left_power == 16'sd0 |-> left_pulse_us == dtem_pkg::PulseCenter)
        else $error("zero left power not centered");

    a_pulse_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> left_pulse_us >= 11'd1100 && left_pulse_us <= 11'd1900
                      && right_pulse_us >= 11'd1100 && right_pulse_us <= 11'd1900)
        else $error("pulse out of range");

    a_pulse_sign: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && right_power > 16'sd0 |-> right_pulse_us > dtem_pkg::PulseCenter)
        else $error("right pulse direction mismatch");

endmodule

`default_nettype wire
